FILE: src/ir_pulse_distance_transmitter_unit_assert.svh
// Assertion macros used by the infrared transmitter's phase sequencer.
`ifndef IR_PULSE_DISTANCE_TRANSMITTER_UNIT_ASSERT_SVH
`define IR_PULSE_DISTANCE_TRANSMITTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define IRPDT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IRPDT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IRPDT_ASSERT(lbl, prop, msg)
`define IRPDT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/irpdt_pkg.sv
// Types and constants shared by the infrared pulse-distance transmitter.
package irpdt_pkg;

    localparam int DUR_W = 14;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [DUR_W-1:0] LEADER_MARK_RST  = 14'd9000;
    localparam logic [DUR_W-1:0] LEADER_SPACE_RST = 14'd4560;
    localparam logic [DUR_W-1:0] BIT_MARK_RST     = 14'd500;
    localparam logic [DUR_W-1:0] ZERO_SPACE_RST   = 14'd500;
    localparam logic [DUR_W-1:0] ONE_SPACE_RST    = 14'd1800;
    localparam logic [DUR_W-1:0] TRAILER_MARK_RST = 14'd560;

    typedef enum logic [2:0] {
        REG_LEADER_MARK  = 3'd0,
        REG_LEADER_SPACE = 3'd1,
        REG_BIT_MARK     = 3'd2,
        REG_ZERO_SPACE   = 3'd3,
        REG_ONE_SPACE    = 3'd4,
        REG_TRAILER_MARK = 3'd5
    } reg_index_t;

    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_LEAD_MARK  = 6'b000010,
        PH_LEAD_SPACE = 6'b000100,
        PH_BIT_MARK   = 6'b001000,
        PH_BIT_SPACE  = 6'b010000,
        PH_TRAIL_MARK = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [DUR_W-1:0] leader_mark;
        logic [DUR_W-1:0] leader_space;
        logic [DUR_W-1:0] bit_mark;
        logic [DUR_W-1:0] zero_space;
        logic [DUR_W-1:0] one_space;
        logic [DUR_W-1:0] trailer_mark;
    } timing_t;

    typedef struct packed {
        logic emitter_on;
        logic sending;
        logic frame_done;
        logic byte_dropped;
    } result_t;

endpackage

FILE: src/irpdt_cfg_regs.sv
// Duration registers of the infrared transmitter and their write decoder.
module irpdt_cfg_regs
    import irpdt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [DUR_W-1:0] cfg_data,
    output timing_t          timing
);

    timing_t timing_reg;
    timing_t timing_next;

    always_comb
    begin
        timing_next = timing_reg;
        if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_LEADER_MARK:  timing_next.leader_mark  = cfg_data;
                REG_LEADER_SPACE: timing_next.leader_space = cfg_data;
                REG_BIT_MARK:     timing_next.bit_mark     = cfg_data;
                REG_ZERO_SPACE:   timing_next.zero_space   = cfg_data;
                REG_ONE_SPACE:    timing_next.one_space    = cfg_data;
                REG_TRAILER_MARK: timing_next.trailer_mark = cfg_data;
                default:          timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.leader_mark  <= LEADER_MARK_RST;
            timing_reg.leader_space <= LEADER_SPACE_RST;
            timing_reg.bit_mark     <= BIT_MARK_RST;
            timing_reg.zero_space   <= ZERO_SPACE_RST;
            timing_reg.one_space    <= ONE_SPACE_RST;
            timing_reg.trailer_mark <= TRAILER_MARK_RST;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

    assign timing = timing_reg;

endmodule

FILE: src/irpdt_byte_store.sv
// Frame byte buffer: one write port and one registered read port.
module irpdt_byte_store
    import irpdt_pkg::*;
#(
    parameter int MAX_BYTES = 16,
    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
)
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [7:0]          wr_data,
    input  logic [AW-1:0]       rd_addr,
    output logic [7:0]          rd_data
);

    localparam int DEPTH = 2 ** AW;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/irpdt_ctrl.sv
// Phase sequencer: buffer fill, duration countdown and bit selection.
`include "ir_pulse_distance_transmitter_unit_assert.svh"
module irpdt_ctrl
    import irpdt_pkg::*;
#(
    parameter int MAX_BYTES = 16,
    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          operation,
    input  logic [7:0]    frame_byte,
    input  logic          last_byte,
    input  timing_t       timing,
    input  logic [7:0]    rd_data,
    output logic [AW-1:0] rd_addr,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output result_t       result
);

    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_BYTES);

    phase_t           phase_reg,  phase_next;
    logic [DUR_W-1:0] ticks_reg,  ticks_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic [CW-1:0]    index_reg,  index_next;
    logic [2:0]       bitpos_reg, bitpos_next;
    logic             done;
    logic             dropped;

    always_comb
    begin
        phase_next  = phase_reg;
        ticks_next  = ticks_reg;
        count_next  = count_reg;
        index_next  = index_reg;
        bitpos_next = bitpos_reg;
        wr_en       = 1'b0;
        done        = 1'b0;
        dropped     = 1'b0;
        if (step)
        begin
            if (operation == OP_PUSH)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    if (count_reg >= MAX_C)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (last_byte && (count_next != '0))
                    begin
                        index_next  = '0;
                        bitpos_next = '0;
                        phase_next  = PH_LEAD_MARK;
                        ticks_next  = timing.leader_mark;
                    end
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (ticks_reg > 14'd1)
                begin
                    ticks_next = ticks_reg - 1'b1;
                end
                else
                begin
                    ticks_next = '0;
                    unique case (phase_reg)
                        PH_LEAD_MARK:
                        begin
                            phase_next = PH_LEAD_SPACE;
                            ticks_next = timing.leader_space;
                        end
                        PH_LEAD_SPACE:
                        begin
                            phase_next = PH_BIT_MARK;
                            ticks_next = timing.bit_mark;
                        end
                        PH_BIT_MARK:
                        begin
                            phase_next = PH_BIT_SPACE;
                            ticks_next = rd_data[bitpos_reg] ? timing.one_space
                                                             : timing.zero_space;
                        end
                        PH_BIT_SPACE:
                        begin
                            if (bitpos_reg == 3'd7)
                            begin
                                bitpos_next = '0;
                                index_next  = index_reg + 1'b1;
                            end
                            else
                            begin
                                bitpos_next = bitpos_reg + 1'b1;
                            end
                            if (index_next >= count_reg)
                            begin
                                phase_next = PH_TRAIL_MARK;
                                ticks_next = timing.trailer_mark;
                            end
                            else
                            begin
                                phase_next = PH_BIT_MARK;
                                ticks_next = timing.bit_mark;
                            end
                        end
                        PH_TRAIL_MARK:
                        begin
                            phase_next  = PH_IDLE;
                            count_next  = '0;
                            index_next  = '0;
                            bitpos_next = '0;
                            done        = 1'b1;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    // The store is read at the byte index that the sequencer moves to, so the
    // registered data already belongs to the current byte on the next cycle.
    // Writes happen only while idle, and the leader mark and space pass before
    // the first bit mark ends, so the refreshed read always sees the written byte.
    assign rd_addr = index_next[AW-1:0];
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = frame_byte;

    always_comb
    begin
        result.emitter_on   = (phase_next == PH_LEAD_MARK) ||
                              (phase_next == PH_BIT_MARK) ||
                              (phase_next == PH_TRAIL_MARK);
        result.sending      = (phase_next != PH_IDLE);
        result.frame_done   = done;
        result.byte_dropped = dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            ticks_reg  <= '0;
            count_reg  <= '0;
            index_reg  <= '0;
            bitpos_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            ticks_reg  <= ticks_next;
            count_reg  <= count_next;
            index_reg  <= index_next;
            bitpos_reg <= bitpos_next;
        end
    end

    `IRPDT_ASSERT_ALWAYS(a_count_bound, (!rst_n) || (count_reg <= MAX_C), "stored count beyond buffer depth")
    `IRPDT_ASSERT(a_index_in_frame, ((phase_reg == PH_BIT_MARK) || (phase_reg == PH_BIT_SPACE)) |-> (index_reg < count_reg), "byte index outside stored bytes")
    `IRPDT_ASSERT(a_no_write_busy, (phase_reg != PH_IDLE) |-> !wr_en, "buffer written during a frame")
    `IRPDT_ASSERT(a_done_empties, (step && done) |=> ((phase_reg == PH_IDLE) && (count_reg == '0)), "frame end left state behind")

endmodule

FILE: src/ir_pulse_distance_transmitter_unit.sv
// Top level of the infrared pulse-distance frame transmitter.
//
//  Channel  Direction  Handshake            Payload
//  in       sink       in_valid/in_ready    operation, frame_byte, last_byte
//  out      source     out_valid/out_ready  emitter_on, sending, frame_done, byte_dropped
//  cfg      sink       cfg_write            cfg_index, cfg_data
//
// One request is handled per cycle and one may be taken on every clock, as the
// sequencer state is read, modified and written back in a single pass.
// A result sits in the output register from the cycle after its request is accepted;
// while it waits, a new request is taken only if the consumer takes it in that cycle.
// Reset clears the sequencer and the output valid flag and restores the default
// durations; the byte buffer keeps its contents and needs no clearing.
module ir_pulse_distance_transmitter_unit
    import irpdt_pkg::*;
#(
    parameter int MAX_BYTES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             operation,
    input  logic [7:0]       frame_byte,
    input  logic             last_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             emitter_on,
    output logic             sending,
    output logic             frame_done,
    output logic             byte_dropped,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [DUR_W-1:0] cfg_data
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    timing_t       timing;
    result_t       result;
    result_t       result_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          step;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    rd_data;
    logic [7:0]    wr_data;
    logic          wr_en;

    // The output register frees up in the same cycle its result is taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    irpdt_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    irpdt_byte_store #(
        .MAX_BYTES (MAX_BYTES)
    ) u_byte_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    irpdt_ctrl #(
        .MAX_BYTES (MAX_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .operation  (operation),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .timing     (timing),
        .rd_data    (rd_data),
        .rd_addr    (rd_addr),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .result     (result)
    );

    // The valid flag is set by an accepted request and cleared once the
    // consumer has taken the result without a new one arriving.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The result fields are payload and load only with an accepted request.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign emitter_on   = result_reg.emitter_on;
    assign sending      = result_reg.sending;
    assign frame_done   = result_reg.frame_done;
    assign byte_dropped = result_reg.byte_dropped;

endmodule
